@@ design/ctd_pkg.sv @@
// Shared types and constants for the countdown timer with clock tiles.
`default_nettype none
package ctd_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_STOP    = 3'd2,
    OP_SHOW    = 3'd3,
    OP_REFRESH = 3'd4
  } op_e;

  // Register select is paddr[2]: frames_per_second at 0x0, tile_attribute at 0x4.
  localparam logic REG_FPS  = 1'b0;
  localparam logic REG_ATTR = 1'b1;

  localparam logic [7:0]  FPS_RESET  = 8'd60;
  localparam logic [15:0] ATTR_RESET = 16'h3000;

  localparam int QUEUE_DEPTH = 2;

  localparam int SECS_PER_MIN = 60;
  localparam int MIN_CLAMP    = 99;
  localparam int GLYPH_OFFSET = 31;
  localparam int CHAR_SPACE   = 32;
  localparam int CHAR_ZERO    = 48;
  localparam int CHAR_COLON   = 58;

  // Timer state snapshot handed from the command front end to the renderer.
  typedef struct packed {
    logic [15:0] seconds_left;
    logic        running;
    logic        shown;
    logic        draw;
  } job_t;

  typedef struct packed {
    logic [15:0] cell_second_units;
    logic [15:0] cell_second_tens;
    logic [15:0] cell_colon;
    logic [15:0] cell_minute_units;
    logic [15:0] cell_minute_tens;
    logic        draw;
    logic        shown;
    logic        running;
    logic [15:0] seconds_left;
  } result_t;

endpackage
`default_nettype wire

@@ design/countdown_timer_with_clock_tiles.sv @@
// Countdown timer top level: register port, command front end, job queue, renderer.
// A command beat goes into the job queue, which absorbs stalls, then the renderer.
// Throughput: one command per cycle while the queue is not full; the two-stage
// renderer (reciprocal multiply, then remainder and digit split) sets the latency.
// Reset: timer state, queue and pipeline valids clear asynchronously; the registers
// return to 60 frames per second and tile attribute 0x3000.
`default_nettype none
module countdown_timer_with_clock_tiles #(
  parameter int QUEUE_DEPTH = ctd_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [15:0] seconds, [16] show_flag, [23:17] zero
  input  wire logic [23:0]  s_axis_tdata_i,
  // [2:0] opcode
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [15:0] seconds_left, [16] running, [17] shown, [18] draw,
  // [34:19] cell_minute_tens, [50:35] cell_minute_units, [66:51] cell_colon,
  // [82:67] cell_second_tens, [98:83] cell_second_units, [103:99] zero
  output logic [103:0]      m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]       fps_q;
  logic [15:0]      attr_q;
  logic             cfg_write;
  logic             in_accept;
  logic             queue_full;
  logic             job_valid;
  logic             job_pop;
  ctd_pkg::job_t    job_in;
  ctd_pkg::job_t    job_head;
  ctd_pkg::result_t res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q  <= ctd_pkg::FPS_RESET;
      attr_q <= ctd_pkg::ATTR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == ctd_pkg::REG_FPS) begin
        fps_q <= pwdata[7:0];
      end else begin
        attr_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == ctd_pkg::REG_ATTR) ? {16'd0, attr_q} : {24'd0, fps_q};

  assign s_axis_tready_o = !queue_full;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  ctd_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (in_accept),
    .opcode_i            (s_axis_tuser_i),
    .seconds_i           (s_axis_tdata_i[15:0]),
    .show_flag_i         (s_axis_tdata_i[16]),
    .frames_per_second_i (fps_q),
    .job_o               (job_in)
  );

  ctd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (job_in),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .head_o      (job_head)
  );

  ctd_render u_render (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (job_head),
    .job_pop_o        (job_pop),
    .tile_attribute_i (attr_q),
    .res_valid_o      (m_axis_tvalid_o),
    .res_ready_i      (m_axis_tready_i),
    .res_o            (res)
  );

  assign m_axis_tdata_o = {5'd0, res};

endmodule
`default_nettype wire

@@ design/ctd_front.sv @@
// Command front end: accepts beats, updates the timer state and emits a render job.
`default_nettype none
module ctd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [2:0]     opcode_i,
  input  wire logic [15:0]    seconds_i,
  input  wire logic           show_flag_i,
  input  wire logic [7:0]     frames_per_second_i,
  output ctd_pkg::job_t       job_o
);

  logic [15:0] seconds_q, seconds_d;
  logic [7:0]  frame_q, frame_d;
  logic        run_q, run_d;
  logic        show_q, show_d;
  logic        draw;
  logic [7:0]  frame_inc;

  assign frame_inc = frame_q + 8'd1;

  always_comb begin
    seconds_d = seconds_q;
    frame_d   = frame_q;
    run_d     = run_q;
    show_d    = show_q;
    draw      = 1'b0;
    if (accept_i) begin
      case (opcode_i)
        ctd_pkg::OP_TICK: begin
          if (run_q && (seconds_q != 16'd0)) begin
            frame_d = frame_inc;
            if (frame_inc >= frames_per_second_i) begin
              frame_d   = 8'd0;
              seconds_d = seconds_q - 16'd1;
              if (seconds_q == 16'd1) begin
                run_d = 1'b0;
              end
              draw = show_q;
            end
          end
        end
        ctd_pkg::OP_SET: begin
          seconds_d = seconds_i;
          frame_d   = 8'd0;
          run_d     = 1'b1;
          draw      = 1'b1;
        end
        ctd_pkg::OP_STOP: begin
          run_d = 1'b0;
        end
        ctd_pkg::OP_SHOW: begin
          show_d = show_flag_i;
          draw   = 1'b1;
        end
        ctd_pkg::OP_REFRESH: begin
          draw = show_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= 16'd0;
      frame_q   <= 8'd0;
      run_q     <= 1'b0;
      show_q    <= 1'b0;
    end else begin
      seconds_q <= seconds_d;
      frame_q   <= frame_d;
      run_q     <= run_d;
      show_q    <= show_d;
    end
  end

  assign job_o.seconds_left = seconds_d;
  assign job_o.running      = run_d;
  assign job_o.shown        = show_d;
  assign job_o.draw         = draw;

  a_set_clears_prescaler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (opcode_i == ctd_pkg::OP_SET)) |=> (frame_q == 8'd0) && run_q)
    else $error("set did not restart the prescaler");

  a_stopped_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (opcode_i == ctd_pkg::OP_TICK) && (seconds_q == 16'd1) && job_o.draw)
      |=> !run_q && (seconds_q == 16'd0))
    else $error("timer kept running after reaching zero");

endmodule
`default_nettype wire

@@ design/ctd_fifo.sv @@
// Small job queue between the command front end and the renderer.
`default_nettype none
module ctd_fifo #(
  parameter int DEPTH = ctd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ctd_pkg::job_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ctd_pkg::job_t      head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ctd_pkg::job_t      mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

@@ design/ctd_render.sv @@
// Renderer: splits seconds into MM:SS over two stages and builds the tile words.
`default_nettype none
module ctd_render (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire ctd_pkg::job_t job_i,
  output logic               job_pop_o,
  input  wire logic [15:0]   tile_attribute_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output ctd_pkg::result_t   res_o
);

  // q = floor(s / 60) for every 16-bit s, as (s * 34953) >> 21.
  localparam logic [15:0] Recip60 = 16'd34953;

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

  function automatic logic [15:0] tile(input logic [6:0] ch, input logic [15:0] attr);
    return {9'd0, ch - 7'(ctd_pkg::GLYPH_OFFSET)} | attr;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    return 7'(ctd_pkg::CHAR_ZERO) + {3'd0, d};
  endfunction

  ctd_pkg::job_t    s1_job_q;
  logic [10:0]      s1_quot_q;
  logic             s1_valid_q;
  ctd_pkg::result_t res_q, res_d;
  logic             res_valid_q;
  logic             out_load, s1_load;
  logic [31:0]      product;

  logic [15:0] sec_rem;
  logic [5:0]  sec;
  logic [6:0]  mins;
  logic [3:0]  m_tens, m_units, s_tens, s_units;
  logic        cells_on;

  assign out_load  = !res_valid_q || res_ready_i;
  assign s1_load   = !s1_valid_q || out_load;
  assign job_pop_o = job_valid_i && s1_load;

  assign product = 32'(job_i.seconds_left) * 32'(Recip60);

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_job_q  <= job_i;
      s1_quot_q <= product[31:21];
    end
  end

  always_comb begin
    sec_rem  = s1_job_q.seconds_left - (16'(s1_quot_q) * 16'(ctd_pkg::SECS_PER_MIN));
    sec      = sec_rem[5:0];
    mins     = (s1_quot_q > 11'(ctd_pkg::MIN_CLAMP)) ? 7'(ctd_pkg::MIN_CLAMP) : s1_quot_q[6:0];
    m_tens   = tens_of(mins);
    m_units  = 4'(mins - {m_tens, 3'd0} - {2'd0, m_tens, 1'd0});
    s_tens   = tens_of({1'b0, sec});
    s_units  = 4'({1'b0, sec} - {m_tens & 4'd0, 3'd0} - {s_tens, 3'd0} - {2'd0, s_tens, 1'd0});
    cells_on = s1_job_q.draw && s1_job_q.shown;

    res_d.seconds_left = s1_job_q.seconds_left;
    res_d.running      = s1_job_q.running;
    res_d.shown        = s1_job_q.shown;
    res_d.draw         = s1_job_q.draw;
    res_d.cell_minute_tens  = '0;
    res_d.cell_minute_units = '0;
    res_d.cell_colon        = '0;
    res_d.cell_second_tens  = '0;
    res_d.cell_second_units = '0;
    if (cells_on) begin
      res_d.cell_minute_tens  = (m_tens == 4'd0) ?
                                tile(7'(ctd_pkg::CHAR_SPACE), tile_attribute_i) :
                                tile(digit_char(m_tens), tile_attribute_i);
      res_d.cell_minute_units = tile(digit_char(m_units), tile_attribute_i);
      res_d.cell_colon        = tile(7'(ctd_pkg::CHAR_COLON), tile_attribute_i);
      res_d.cell_second_tens  = tile(digit_char(s_tens), tile_attribute_i);
      res_d.cell_second_units = tile(digit_char(s_units), tile_attribute_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= job_valid_i;
      end
      if (out_load) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_blank_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !(res_q.draw && res_q.shown)) |->
      ((res_q.cell_minute_tens | res_q.cell_minute_units | res_q.cell_colon |
        res_q.cell_second_tens | res_q.cell_second_units) == 16'd0))
    else $error("cells drawn while not drawing or hidden");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (sec_rem < 16'(ctd_pkg::SECS_PER_MIN)))
    else $error("seconds remainder out of range");

endmodule
`default_nettype wire

@@ dv/ctd_checker.sv @@
// Scoreboard for the countdown timer: predicts every result beat from the command stream.
`timescale 1ns / 100ps
module ctd_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tready_i,
  // [15:0] seconds, [16] show_flag, [23:17] zero
  input  logic [23:0]   s_tdata_i,
  // [2:0] opcode
  input  logic [2:0]    s_tuser_i,
  input  logic          m_tvalid_i,
  input  logic          m_tready_i,
  // [15:0] seconds_left, [16] running, [17] shown, [18] draw, [98:19] five cells, [103:99] zero
  input  logic [103:0]  m_tdata_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  input  logic          pready_i,
  output int unsigned   errors_o,
  output int unsigned   pending_o
);
  import ctd_pkg::*;

  logic [7:0]  fps_q;
  logic [15:0] attr_q;
  logic [15:0] secs_q;
  logic [7:0]  prescale_q;
  logic        running_q;
  logic        shown_q;
  result_t     expected_rows[$];
  int unsigned mismatches;

  function automatic logic [15:0] tile_of(int ch);
    return 16'(ch - GLYPH_OFFSET) | attr_q;
  endfunction

  task automatic step_timer(input logic [2:0] code, input logic [15:0] secs_in,
                            input logic flag, output result_t row);
    logic        do_draw;
    int unsigned mins;
    int unsigned secs;
    do_draw = 1'b0;
    row = '0;
    case (code)
      OP_TICK: begin
        if (running_q && secs_q != 16'd0) begin
          prescale_q = prescale_q + 8'd1;
          // A prescaler left above a lowered rate fires at once.
          if (prescale_q >= fps_q) begin
            prescale_q = '0;
            secs_q = secs_q - 16'd1;
            if (secs_q == 16'd0) running_q = 1'b0;
            do_draw = shown_q;
          end
        end
      end
      OP_SET: begin
        secs_q = secs_in;
        prescale_q = '0;
        running_q = 1'b1;
        do_draw = 1'b1;
      end
      OP_STOP: running_q = 1'b0;
      OP_SHOW: begin
        shown_q = flag;
        do_draw = 1'b1;
      end
      OP_REFRESH: do_draw = shown_q;
      default: ;
    endcase
    row.seconds_left = secs_q;
    row.running = running_q;
    row.shown = shown_q;
    row.draw = do_draw;
    if (do_draw && shown_q) begin
      mins = secs_q / SECS_PER_MIN;
      secs = secs_q % SECS_PER_MIN;
      if (mins > MIN_CLAMP) mins = MIN_CLAMP;
      row.cell_minute_tens = (mins < 10) ? tile_of(CHAR_SPACE) : tile_of(CHAR_ZERO + mins / 10);
      row.cell_minute_units = tile_of(CHAR_ZERO + mins % 10);
      row.cell_colon = tile_of(CHAR_COLON);
      row.cell_second_tens = tile_of(CHAR_ZERO + secs / 10);
      row.cell_second_units = tile_of(CHAR_ZERO + secs % 10);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      fps_q = FPS_RESET;
      attr_q = ATTR_RESET;
      secs_q = '0;
      prescale_q = '0;
      running_q = 1'b0;
      shown_q = 1'b0;
      expected_rows.delete();
    end else begin
      // The result beat is retired first; a command accepted on the same edge is younger.
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[98:0];
        if (expected_rows.size() == 0) begin
          $error("result beat with no command waiting");
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          check_field("seconds_left", want.seconds_left, got.seconds_left);
          check_field("running", 16'(want.running), 16'(got.running));
          check_field("shown", 16'(want.shown), 16'(got.shown));
          check_field("draw", 16'(want.draw), 16'(got.draw));
          check_field("cell_minute_tens", want.cell_minute_tens, got.cell_minute_tens);
          check_field("cell_minute_units", want.cell_minute_units, got.cell_minute_units);
          check_field("cell_colon", want.cell_colon, got.cell_colon);
          check_field("cell_second_tens", want.cell_second_tens, got.cell_second_tens);
          check_field("cell_second_units", want.cell_second_units, got.cell_second_units);
          check_field("tdata padding", 16'(m_tdata_i[103:99]), 16'd0);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        step_timer(s_tuser_i, s_tdata_i[15:0], s_tdata_i[16], want);
        expected_rows.push_back(want);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_FPS:  fps_q = pwdata_i[7:0];
          REG_ATTR: attr_q = pwdata_i[15:0];
          default: ;
        endcase
      end
    end
    errors_o = mismatches;
    pending_o = expected_rows.size();
  end

endmodule

@@ dv/countdown_timer_with_clock_tiles_tb.sv @@
// Testbench top for the countdown timer: command and register stimulus, stalls and verdict.
`timescale 1ns / 100ps
module countdown_timer_with_clock_tiles_tb;
  import ctd_pkg::*;

  localparam int          N_PHASES        = 7;
  localparam int          ITEMS_PER_PHASE = 155;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          CYCLE_LIMIT     = 300000;
  localparam logic [2:0]  FPS_ADDR        = {REG_FPS, 2'b00};
  localparam logic [2:0]  ATTR_ADDR       = {REG_ATTR, 2'b00};

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata;
  logic [2:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  int unsigned   check_errors;
  int unsigned   rows_pending;
  int unsigned   cycle_count;
  int unsigned   rx_hold;
  bit            tx_no_gaps;
  bit            rx_no_stalls;

  countdown_timer_with_clock_tiles DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  ctd_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .errors_o   (check_errors),
    .pending_o  (rows_pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: after each accepted beat, stall for a drawn number of cycles unless stalls are off.
  initial begin
    rx_hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) rx_hold = rx_no_stalls ? 0 : $urandom_range(0, 12);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(input logic [2:0] code, input logic [15:0] secs, input logic flag);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, flag, secs};
    s_axis_tuser <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (rows_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // The bus goes idle before the task returns.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  phase_fps [N_PHASES];
    logic [15:0] attr;
    logic [2:0]  code;
    logic [15:0] secs;
    logic        flag;
    int unsigned pick;

    phase_fps = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd60, 8'd2, 8'd7};
    tx_no_gaps = 1'b0;
    rx_no_stalls = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part under the reset register values.
    send_cmd(OP_TICK, 16'hFFFF, 1'b1);      // idle tick while stopped
    send_cmd(OP_REFRESH, 16'h0000, 1'b1);   // hidden, so nothing is drawn
    send_cmd(OP_SHOW, 16'h0000, 1'b1);
    send_cmd(OP_SET, 16'd0, 1'b0);
    send_cmd(OP_TICK, 16'h0000, 1'b0);      // running with zero seconds does nothing
    send_cmd(OP_SET, 16'hFFFF, 1'b0);       // minutes clamp to 99
    send_cmd(OP_REFRESH, 16'hFFFF, 1'b0);
    send_cmd(OP_SET, 16'd599, 1'b1);        // minutes tens drawn as a space
    send_cmd(OP_SET, 16'd600, 1'b1);
    send_cmd(OP_SET, 16'd5999, 1'b1);
    send_cmd(OP_SET, 16'd6000, 1'b1);
    send_cmd(OP_STOP, 16'hFFFF, 1'b1);
    send_cmd(OP_TICK, 16'h0000, 1'b0);
    send_cmd(3'd5, 16'hFFFF, 1'b1);
    send_cmd(3'd6, 16'hFFFF, 1'b1);
    send_cmd(3'd7, 16'hFFFF, 1'b1);
    send_cmd(OP_SHOW, 16'hFFFF, 1'b0);      // hidden draw gives zero cells
    send_cmd(OP_REFRESH, 16'h0000, 1'b0);
    send_cmd(OP_SHOW, 16'h0000, 1'b1);
    send_cmd(OP_SET, 16'd100, 1'b0);
    send_cmd(OP_TICK, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 16'h0000, 1'b0);
    hold_until_drained();
    // The prescaler now sits above the new rate and fires on the next tick.
    apb_write(FPS_ADDR, 32'd1);
    send_cmd(OP_TICK, 16'h0000, 1'b0);
    send_cmd(OP_SET, 16'd2, 1'b0);
    send_cmd(OP_TICK, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 16'h0000, 1'b0);      // reaches zero and stops
    send_cmd(OP_TICK, 16'h0000, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      hold_until_drained();
      if (p == 0) attr = 16'hFFFF;
      else if (p == 1) attr = 16'h0000;
      else attr = 16'($urandom_range(0, 65535));
      apb_write(FPS_ADDR, {24'd0, phase_fps[p]});
      apb_write(ATTR_ADDR, {16'd0, attr});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          tx_no_gaps = ($urandom_range(0, 3) == 0);
          rx_no_stalls = ($urandom_range(0, 3) == 0);
        end
        pick = $urandom_range(0, 99);
        secs = 16'($urandom_range(0, 65535));
        flag = 1'($urandom_range(0, 1));
        if (pick < 55) begin
          code = OP_TICK;
        end else if (pick < 67) begin
          code = OP_SET;
          // Mostly short counts so the timer reaches zero within a phase.
          case ($urandom_range(0, 9))
            0: ;
            1, 2: secs = 16'($urandom_range(0, 700));
            default: secs = 16'($urandom_range(0, 8));
          endcase
        end else if (pick < 72) begin
          code = OP_STOP;
        end else if (pick < 82) begin
          code = OP_SHOW;
          flag = ($urandom_range(0, 9) < 7);
        end else if (pick < 97) begin
          code = OP_REFRESH;
        end else begin
          code = 3'($urandom_range(5, 7));
        end
        send_cmd(code, secs, flag);
      end
    end

    hold_until_drained();
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
